// ----- hdl/surt_pkg.sv -----
// Shared types and constants for the soft UART receiver with idle timeout.
`default_nettype none
package surt_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 20;
  localparam int unsigned BIT_TICKS_W     = 16;
  localparam int unsigned HALF_TICKS_W    = 16;
  localparam int unsigned TIMEOUT_W       = 20;
  localparam int unsigned CFG_DATA_W      = 20;
  localparam int unsigned CFG_INDEX_W     = 2;

  localparam logic                   INVERT_RST  = 1'b1;
  localparam logic [BIT_TICKS_W-1:0] BIT_RST     = 16'd128;
  localparam logic [HALF_TICKS_W-1:0] HALF_RST   = 16'd60;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST = 20'd655350;
  localparam logic [7:0]             TIMEOUT_BYTE = 8'hff;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INVERT  = 2'd0,
    REG_BIT     = 2'd1,
    REG_HALF    = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HALF  = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_GUARD = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                    invert_polarity;
    logic [BIT_TICKS_W-1:0]  bit_ticks;
    logic [HALF_TICKS_W-1:0] half_ticks;
    logic [TIMEOUT_W-1:0]    timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       timed_out;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/soft_uart_receiver_timeout.sv -----
// Soft UART receiver (8N1, no stop check) with idle timeout: top level.
//
// One line sample is taken per cycle while the skid stage is not full: a sample
// transfers on in_valid and in_ready and is processed in that cycle. A byte
// or timeout result lands in the output register on the clock edge that takes the
// sample producing it; a second result waits in a skid stage, and in_ready drops
// only while that skid stage is full. Configuration writes take effect at once and
// are always accepted. The tick counter is COUNT_WIDTH bits wide.
`default_nettype none
module soft_uart_receiver_timeout #(
  parameter int unsigned COUNT_WIDTH = surt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             line_level,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [7:0]                            data_byte,
  output logic                                  timed_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [surt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [surt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import surt_pkg::*;

  cfg_t    cfg;
  logic    take;
  logic    push;
  logic    space;
  result_t fsm_result;
  result_t out_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign take      = in_valid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_polarity <= INVERT_RST;
      cfg.bit_ticks       <= BIT_RST;
      cfg.half_ticks      <= HALF_RST;
      cfg.timeout_ticks   <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_INVERT:  cfg.invert_polarity <= cfg_data[0];
        REG_BIT:     cfg.bit_ticks       <= cfg_data[BIT_TICKS_W-1:0];
        REG_HALF:    cfg.half_ticks      <= cfg_data[HALF_TICKS_W-1:0];
        REG_TIMEOUT: cfg.timeout_ticks   <= cfg_data[TIMEOUT_W-1:0];
        default:     cfg.invert_polarity <= cfg.invert_polarity;
      endcase
    end
  end

  surt_rx_fsm #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .line_level (line_level),
    .cfg        (cfg),
    .push       (push),
    .result     (fsm_result)
  );

  surt_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (fsm_result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign data_byte = out_data.data_byte;
  assign timed_out = out_data.timed_out;

endmodule
`default_nettype wire

// ----- hdl/surt_rx_fsm.sv -----
// Receive state machine: start detect, bit timing, shift, timeout and guard.
`default_nettype none
module surt_rx_fsm #(
  parameter int unsigned COUNT_WIDTH = surt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic             line_level,
  input  wire surt_pkg::cfg_t   cfg,
  output logic                  push,
  output surt_pkg::result_t     result
);
  import surt_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > BIT_TICKS_W) ? COUNT_WIDTH : BIT_TICKS_W;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]             bit_index, bit_index_next;
  logic [7:0]             shift_value, shift_value_next;

  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [COUNT_WIDTH-1:0] timeout_m;
  logic [BIT_TICKS_W-1:0] bt;
  logic [7:0]             shifted;
  logic                   start_seen;
  logic                   bit_done;
  logic                   half_done;

  assign tick_inc   = tick_count + 1'b1;
  assign timeout_m  = COUNT_WIDTH'(cfg.timeout_ticks);
  assign bt         = (cfg.bit_ticks == '0) ? BIT_TICKS_W'(1) : cfg.bit_ticks;
  assign shifted    = {line_level ^ cfg.invert_polarity, shift_value[7:1]};
  assign start_seen = (line_level == cfg.invert_polarity);
  assign bit_done   = CMP_W'(tick_inc) >= CMP_W'(bt);
  assign half_done  = CMP_W'(tick_inc) >= CMP_W'(cfg.half_ticks);

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    shift_value_next = shift_value;
    push             = 1'b0;
    result           = '{data_byte: shift_value, timed_out: 1'b0};
    unique case (phase)
      PH_IDLE: begin
        if (start_seen) begin
          tick_count_next  = '0;
          bit_index_next   = '0;
          shift_value_next = '0;
          phase_next       = (cfg.half_ticks == '0) ? PH_DATA : PH_HALF;
        end else if (cfg.invert_polarity) begin
          if (tick_inc == timeout_m) begin
            tick_count_next = '0;
            push            = 1'b1;
            result          = '{data_byte: TIMEOUT_BYTE, timed_out: 1'b1};
          end else begin
            tick_count_next = tick_inc;
          end
        end else begin
          tick_count_next = '0;
        end
      end
      PH_HALF: begin
        tick_count_next = tick_inc;
        if (half_done) begin
          tick_count_next = '0;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        tick_count_next = tick_inc;
        if (bit_done) begin
          tick_count_next  = '0;
          shift_value_next = shifted;
          bit_index_next   = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            if (cfg.invert_polarity) begin
              phase_next = PH_GUARD;
            end else begin
              phase_next = PH_IDLE;
              push       = 1'b1;
              result     = '{data_byte: shifted, timed_out: 1'b0};
            end
          end
        end
      end
      PH_GUARD: begin
        tick_count_next = tick_inc;
        if (bit_done) begin
          tick_count_next = '0;
          phase_next      = PH_IDLE;
          push            = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    // no state change and no result without a transfer
    if (!take) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      shift_value <= '0;
    end else if (take) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      shift_value <= shift_value_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/surt_out_buf.sv -----
// Two-entry result buffer: output register plus skid stage.
`default_nettype none
module surt_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire surt_pkg::result_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output surt_pkg::result_t      out_data
);
  import surt_pkg::*;

  result_t main_data, skid_data;
  logic    main_valid, skid_valid;
  logic    pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      // refill the output register, skid entry first
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end
    if (main_valid && !pop && push) begin
      skid_data <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- test/soft_uart_receiver_timeout_tb.sv -----
// Self-checking testbench for the soft UART receiver with idle timeout.
`default_nettype none
module soft_uart_receiver_timeout_tb;
  import surt_pkg::*;

  localparam int unsigned CNT_W       = COUNT_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   line_level = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             data_byte;
  logic                   timed_out;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  soft_uart_receiver_timeout uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .line_level (line_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .timed_out  (timed_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver model: settings and state
  logic                    rx_inv     = INVERT_RST;
  logic [BIT_TICKS_W-1:0]  rx_bit     = BIT_RST;
  logic [HALF_TICKS_W-1:0] rx_half    = HALF_RST;
  logic [TIMEOUT_W-1:0]    rx_timeout = TIMEOUT_RST;
  phase_t                  rx_phase   = PH_IDLE;
  logic [CNT_W-1:0]        rx_ticks   = '0;
  logic [2:0]              rx_bit_idx = '0;
  logic [7:0]              rx_shift   = '0;

  logic    line_queue[$];
  result_t byte_expect[$];

  int unsigned samples_queued    = 0;
  int unsigned results_predicted = 0;
  int unsigned error_count       = 0;
  int unsigned cycle_count       = 0;

  logic        in_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 50) $display("cycle %0d: %s", cycle_count, what);
  endtask

  // Advance the receiver model by one line sample.
  task automatic predict_sample(input logic line);
    logic [BIT_TICKS_W-1:0] bt;
    result_t                res;
    logic                   emit;
    bt = (rx_bit == '0) ? BIT_TICKS_W'(1) : rx_bit;
    res = '0;
    emit = 1'b0;
    case (rx_phase)
      PH_IDLE: begin
        if (line == rx_inv) begin
          rx_ticks = '0;
          rx_bit_idx = '0;
          rx_shift = '0;
          rx_phase = (rx_half == '0) ? PH_DATA : PH_HALF;
        end else if (rx_inv) begin
          rx_ticks = rx_ticks + 1'b1;
          if (rx_ticks == rx_timeout) begin
            rx_ticks = '0;
            res.data_byte = TIMEOUT_BYTE;
            res.timed_out = 1'b1;
            emit = 1'b1;
          end
        end else begin
          rx_ticks = '0;
        end
      end
      PH_HALF: begin
        rx_ticks = rx_ticks + 1'b1;
        if (rx_ticks >= rx_half) begin
          rx_ticks = '0;
          rx_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        rx_ticks = rx_ticks + 1'b1;
        if (rx_ticks >= bt) begin
          rx_ticks = '0;
          rx_shift = {line ^ rx_inv, rx_shift[7:1]};
          if (rx_bit_idx != 3'd7) begin
            rx_bit_idx = rx_bit_idx + 1'b1;
          end else begin
            rx_bit_idx = '0;
            if (rx_inv) begin
              rx_phase = PH_GUARD;
            end else begin
              rx_phase = PH_IDLE;
              res.data_byte = rx_shift;
              emit = 1'b1;
            end
          end
        end
      end
      default: begin
        rx_ticks = rx_ticks + 1'b1;
        if (rx_ticks >= bt) begin
          rx_ticks = '0;
          rx_phase = PH_IDLE;
          res.data_byte = rx_shift;
          emit = 1'b1;
        end
      end
    endcase
    if (emit) begin
      byte_expect.push_back(res);
      results_predicted++;
    end
  endtask

  // Sender: bursts of samples with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (line_queue.size() != 0) begin
        in_valid <= 1'b1;
        line_level <= line_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          case ($urandom_range(0, 7))
            0, 1:    gap_left <= $urandom_range(1, 4);
            2:       gap_left <= $urandom_range(5, 24);
            default: gap_left <= 0;
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall pattern plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(8, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
  end

  // Sample accepted transfers on both channels
  always @(posedge clk) begin
    result_t want;
    cycle_count <= cycle_count + 1;
    in_taken <= in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (byte_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h flag %0b", data_byte, timed_out));
      end else begin
        want = byte_expect.pop_front();
        if (data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %02h, want %02h", data_byte, want.data_byte));
        if (timed_out !== want.timed_out)
          report_mismatch($sformatf("timed_out %0b, want %0b", timed_out, want.timed_out));
      end
    end
    if (!rst && in_valid && in_ready) predict_sample(line_level);
  end

  task automatic push_level(input logic level, input int unsigned count);
    repeat (count) begin
      line_queue.push_back(level);
      samples_queued++;
    end
  endtask

  // One 8N1 frame: idle run, start, eight data bits LSB first, stop
  task automatic push_frame(input logic inv, input int unsigned ticks, input logic [7:0] value,
                            input int unsigned idle_len);
    push_level(!inv, idle_len);
    push_level(inv, ticks);
    for (int k = 0; k < 8; k++) push_level(value[k] ^ inv, ticks);
    push_level(!inv, ticks);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INVERT:  rx_inv = value[0];
      REG_BIT:     rx_bit = value[BIT_TICKS_W-1:0];
      REG_HALF:    rx_half = value[HALF_TICKS_W-1:0];
      REG_TIMEOUT: rx_timeout = value[TIMEOUT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued sample went in and every result came out.
  task automatic wait_idle();
    while (line_queue.size() != 0 || in_valid || byte_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random_phase();
    logic        inv;
    int unsigned bt;
    int unsigned eff;
    int unsigned tmo;
    int unsigned nframes;
    inv = 1'($urandom_range(0, 1));
    bt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
    eff = (bt == 0) ? 1 : bt;
    tmo = $urandom_range(4, 60);
    write_reg(REG_INVERT, CFG_DATA_W'(inv));
    write_reg(REG_BIT, CFG_DATA_W'(bt));
    write_reg(REG_HALF, CFG_DATA_W'($urandom_range(0, eff - 1)));
    write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
    nframes = $urandom_range(3, 8);
    repeat (nframes) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 20)) push_level(1'($urandom_range(0, 1)), 1);
        end
        1: begin
          // truncated frame
          push_level(!inv, $urandom_range(0, 2 * eff));
          push_level(inv, eff);
          repeat ($urandom_range(0, 6)) push_level(1'($urandom_range(0, 1)), eff);
        end
        2: begin
          // idle long enough to time out when inverted
          push_frame(inv, eff, 8'($urandom_range(0, 255)), $urandom_range(tmo, 2 * tmo + 5));
        end
        default: push_frame(inv, eff, 8'($urandom_range(0, 255)), $urandom_range(0, 3 * eff));
      endcase
    end
    wait_idle();
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("** soft_uart_receiver_timeout: FAILED **");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: idle lows, then a start that parks in the half-bit wait
    push_level(1'b0, 12);
    push_level(1'b1, 1);
    push_level(1'b0, 3);
    wait_idle();
    // Shorten the waits mid-frame; upper data bits beyond the field are dropped
    write_reg(REG_HALF, 20'd1);
    write_reg(REG_BIT, 20'hA0001);
    push_level(1'b0, 1);
    for (int k = 0; k < 8; k++) push_level(1'(~(8'hA5 >> k)), 1);
    push_level(1'b0, 3);
    wait_idle();

    // Normal polarity, zero bit count, zero half count, all-zero and all-one bytes
    write_reg(REG_INVERT, 20'hFFFFE);
    write_reg(REG_BIT, 20'd0);
    write_reg(REG_HALF, 20'd0);
    push_frame(1'b0, 1, 8'h00, 3);
    push_frame(1'b0, 1, 8'hFF, 2);
    push_frame(1'b0, 1, 8'h5A, 0);
    wait_idle();

    // Zero timeout never fires within a short idle stretch
    write_reg(REG_INVERT, 20'd1);
    write_reg(REG_TIMEOUT, 20'd0);
    push_level(1'b0, 10);
    push_frame(1'b1, 1, 8'h3C, 0);
    wait_idle();

    // Largest counts, then shrink them while the frame is under way
    write_reg(REG_BIT, 20'd65535);
    write_reg(REG_HALF, 20'd65535);
    write_reg(REG_TIMEOUT, 20'hFFFFF);
    push_level(1'b1, 1);
    push_level(1'b0, 4);
    wait_idle();
    write_reg(REG_HALF, 20'd2);
    push_level(1'b0, 3);
    wait_idle();
    write_reg(REG_BIT, 20'd1);
    push_level(1'b1, 1);
    push_level(1'b0, 1);
    push_level(1'b1, 2);
    push_level(1'b0, 5);
    wait_idle();
    write_reg(REG_TIMEOUT, 20'd7);
    push_level(1'b0, 20);
    wait_idle();

    // Timeout of one: a result per idle sample while the result side holds off
    write_reg(REG_TIMEOUT, 20'd1);
    @(posedge clk);
    hold_req = ~hold_req;
    push_level(1'b0, 200);
    wait_idle();

    while (samples_queued < 850 || results_predicted < 48) run_random_phase();

    wait_idle();
    if (error_count == 0 && byte_expect.size() == 0) begin
      $display("** soft_uart_receiver_timeout: PASSED **");
    end else begin
      $display("** soft_uart_receiver_timeout: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/surt_pkg.sv
hdl/surt_rx_fsm.sv
hdl/surt_out_buf.sv
hdl/soft_uart_receiver_timeout.sv
test/soft_uart_receiver_timeout_tb.sv
